[hw/rtl/lced_pkg.sv]
// Package for the lidar corner and wall-edge detector.
// Holds the widths, result codes, register map and transfer payload types.
// No dependencies; imported by every module of the block.
package lced_pkg;

    // Scan and window geometry
    localparam int MAX_SCAN_POINTS = 4096;
    localparam int HALF_WINDOW     = 5;
    localparam int WIN_DEPTH       = 2 * HALF_WINDOW + 1;

    // Field widths
    localparam int RANGE_W = 16;
    localparam int TOL_W   = 14;
    localparam int POS_W   = 12;
    localparam int COUNT_W = 12;
    localparam int IDX_W   = $clog2(MAX_SCAN_POINTS + 1);
    localparam int SUM_W   = RANGE_W + $clog2(HALF_WINDOW + 1);
    localparam int LIMIT_W = TOL_W + $clog2(HALF_WINDOW + 1);

    // Configuration port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = RANGE_W'(5010);
    localparam logic [TOL_W-1:0]   TOLERANCE_RESET = TOL_W'(400);

    // Register index, taken from paddr[2]
    localparam logic REG_MAX_RANGE = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    localparam logic [IDX_W-1:0]   IDX_MAX     = IDX_W'(MAX_SCAN_POINTS);
    localparam logic [IDX_W-1:0]   IDX_FIRST   = IDX_W'(WIN_DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    typedef enum logic [1:0] {
        KIND_FLAT    = 2'd0,
        KIND_EDGE    = 2'd1,
        KIND_CORNER  = 2'd2,
        KIND_SUMMARY = 2'd3
    } kind_t;

    // One window slot: valid flag and raw range
    typedef struct packed {
        logic               valid;
        logic [RANGE_W-1:0] range;
    } win_entry_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               scan_end;
    } in_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        kind_t              kind;
        logic [COUNT_W-1:0] corner_count;
        logic               last_of_scan;
    } out_t;

endpackage

[hw/rtl/lidar_corner_edge_detector.sv]
// Top level of the lidar corner and wall-edge detector.
// Depends on lced_pkg for widths, codes and payload types.
// Takes one range sample per transfer and emits classifications and scan summaries.

// The block accepts one range sample per clock cycle, sustained, as long as the
// result side keeps taking results. A sample moves through two register stages:
// the eleven-entry sample window with a small pending-item register, then the
// result register. The result register loads from the window and pending-item
// register whenever the result stage advances, that is while it is empty or being drained.
// The window sums, their difference and the tolerance compare sit between these
// two stages. Samples before the first full window and samples past the maximum
// scan length give no result; the sample flagged scan_end gives a summary and
// clears the window, index and corner count for the next scan. Configuration
// writes should be made only while no sample is in flight.
module lidar_corner_edge_detector (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lced_pkg::in_t         s_data,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output lced_pkg::out_t        m_data,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [lced_pkg::ADDR_W-1:0] paddr,
    input  logic [lced_pkg::DATA_W-1:0] pwdata,
    output logic [lced_pkg::DATA_W-1:0] prdata,
    output logic                  pready
);
    import lced_pkg::*;

    // Configuration registers
    logic [RANGE_W-1:0] max_range_reg;
    logic [TOL_W-1:0]   tolerance_reg;
    logic               cfg_wr;

    // Window stage
    win_entry_t         win_reg [WIN_DEPTH];
    logic [IDX_W-1:0]   index_reg, index_next;
    logic               pend_valid_reg;
    logic               pend_end_reg;
    logic               pend_class_reg;
    logic [POS_W-1:0]   pend_pos_reg;
    logic               s_accept;

    // Result stage
    logic               m_valid_reg;
    out_t               m_data_reg;
    logic [COUNT_W-1:0] corner_reg, corner_next;
    logic               res_adv;

    // Classification signals
    logic [SUM_W-1:0]   prior_sum, later_sum, diff;
    logic               ok_before, ok_after;
    logic [LIMIT_W-1:0] limit;
    kind_t              kind;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_range_reg <= MAX_RANGE_RESET;
            tolerance_reg <= TOLERANCE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MAX_RANGE: max_range_reg <= pwdata[RANGE_W-1:0];
                REG_TOLERANCE: tolerance_reg <= pwdata[TOL_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[2])
            REG_MAX_RANGE: prdata = DATA_W'(max_range_reg);
            REG_TOLERANCE: prdata = DATA_W'(tolerance_reg);
            default:       prdata = '0;
        endcase
    end

    // Handshake: result stage moves when its register is free or being drained
    assign res_adv  = !m_valid_reg || m_ready;
    assign s_ready  = !pend_valid_reg || res_adv;
    assign s_accept = s_valid && s_ready;

    // Sample index, saturating at the scan limit and cleared by scan_end
    always_comb begin
        index_next = index_reg;
        if (s_data.scan_end) begin
            index_next = '0;
        end else if (index_reg < IDX_MAX) begin
            index_next = index_reg + IDX_W'(1);
        end
    end

    // Window shift and index update on each accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg <= '0;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s_accept) begin
            index_reg <= index_next;
            if (s_data.scan_end) begin
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    win_reg[k] <= '0;
                end
            end else begin
                for (int k = WIN_DEPTH - 1; k > 0; k--) begin
                    win_reg[k] <= win_reg[k-1];
                end
                win_reg[0].range <= s_data.range_mm;
                win_reg[0].valid <= (s_data.range_mm < max_range_reg);
            end
        end
    end

    // Pending item: what the result stage must do with the current window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (s_ready) begin
            pend_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_end_reg   <= s_data.scan_end;
            pend_class_reg <= !s_data.scan_end && (index_reg < IDX_MAX)
                              && (index_reg >= IDX_FIRST);
            pend_pos_reg   <= POS_W'(index_reg - IDX_W'(HALF_WINDOW));
        end
    end

    // Window sums: newest samples are after the center, oldest before it
    always_comb begin
        later_sum = '0;
        prior_sum = '0;
        ok_after  = 1'b1;
        ok_before = 1'b1;
        for (int k = 0; k < HALF_WINDOW; k++) begin
            later_sum = later_sum + SUM_W'(win_reg[k].range);
            ok_after  = ok_after && win_reg[k].valid;
            prior_sum = prior_sum + SUM_W'(win_reg[HALF_WINDOW + 1 + k].range);
            ok_before = ok_before && win_reg[HALF_WINDOW + 1 + k].valid;
        end
    end

    // Difference against the scaled tolerance
    assign diff  = (prior_sum > later_sum) ? (prior_sum - later_sum)
                                           : (later_sum - prior_sum);
    assign limit = LIMIT_W'(tolerance_reg) * LIMIT_W'(HALF_WINDOW);

    always_comb begin
        if (!ok_before || !ok_after || prior_sum == '0 || later_sum == '0) begin
            kind = KIND_EDGE;
        end else if (diff < SUM_W'(limit)) begin
            kind = KIND_FLAT;
        end else begin
            kind = KIND_CORNER;
        end
    end

    // Corner count, saturating, cleared by the summary
    always_comb begin
        corner_next = corner_reg;
        if (pend_valid_reg) begin
            if (pend_end_reg) begin
                corner_next = '0;
            end else if (pend_class_reg && kind == KIND_CORNER && corner_reg != COUNT_MAX) begin
                corner_next = corner_reg + COUNT_W'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            corner_reg  <= '0;
        end else if (res_adv) begin
            m_valid_reg <= pend_valid_reg && (pend_end_reg || pend_class_reg);
            corner_reg  <= corner_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_adv) begin
            if (pend_end_reg) begin
                m_data_reg.position     <= '0;
                m_data_reg.kind         <= KIND_SUMMARY;
                m_data_reg.corner_count <= corner_reg;
                m_data_reg.last_of_scan <= 1'b1;
            end else begin
                m_data_reg.position     <= pend_pos_reg;
                m_data_reg.kind         <= kind;
                m_data_reg.corner_count <= corner_next;
                m_data_reg.last_of_scan <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hw/rtl/lced_checker.sv]
// Port-level checker for the lidar corner and wall-edge detector.
// Depends on lced_pkg; bound to lidar_corner_edge_detector at the end of this file.
// Watches the result channel for consistency of the reported items.
module lced_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input lced_pkg::out_t m_data
);
    import lced_pkg::*;

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Only the summary closes a scan
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last_of_scan == (m_data.kind == KIND_SUMMARY)))
        else $error("last_of_scan disagrees with kind");

    // Summary reports position zero
    a_sum_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_SUMMARY |-> m_data.position == '0)
        else $error("summary with nonzero position");

    // Classified centres have a full window before them
    a_min_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_SUMMARY
        |-> m_data.position >= POS_W'(HALF_WINDOW + 1))
        else $error("classification before first full window");

endmodule

bind lidar_corner_edge_detector lced_checker u_lced_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[tb/sv/lced_result_checker.sv]
// Result checker for the lidar corner and wall-edge detector.
// Watches the sample, result and configuration ports, predicts every result
// and compares it with the block's output. Depends on lced_pkg.
`timescale 1ns / 1ps

module lced_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  lced_pkg::in_t                 s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  lced_pkg::out_t                m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [lced_pkg::ADDR_W-1:0]   paddr,
    input  logic [lced_pkg::DATA_W-1:0]   pwdata,
    output int                            error_count,
    output int                            outstanding
);
    import lced_pkg::*;

    // Predictor state: configuration copy, sample window, scan index, corner count
    logic [RANGE_W-1:0] max_range;
    logic [TOL_W-1:0]   tolerance;
    win_entry_t         range_window [WIN_DEPTH];
    logic [IDX_W-1:0]   scan_idx;
    logic [COUNT_W-1:0] corners;

    out_t queued_classes [$];
    int   fail_total = 0;

    assign error_count = fail_total;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_total++;
    endtask

    task automatic clear_scan_state();
        for (int k = 0; k < WIN_DEPTH; k++) range_window[k] = '0;
        scan_idx = '0;
        corners  = '0;
    endtask

    // Shift one sample in and queue the result it causes, if any
    task automatic classify_sample(input in_t smp);
        out_t             res;
        logic [IDX_W-1:0] j;
        int unsigned      prior_sum;
        int unsigned      later_sum;
        int unsigned      diff;
        int unsigned      limit;
        logic             all_valid;
        j = scan_idx;
        for (int k = WIN_DEPTH - 1; k > 0; k--) range_window[k] = range_window[k-1];
        range_window[0].valid = (smp.range_mm < max_range);
        range_window[0].range = smp.range_mm;

        if (smp.scan_end) begin
            res.position     = '0;
            res.kind         = KIND_SUMMARY;
            res.corner_count = corners;
            res.last_of_scan = 1'b1;
            queued_classes.push_back(res);
            clear_scan_state();
        end else begin
            if (scan_idx < IDX_MAX) scan_idx++;
            if (j < IDX_MAX && j >= IDX_FIRST) begin
                // newest HALF_WINDOW slots are "after", oldest HALF_WINDOW are "before"
                prior_sum = 0;
                later_sum = 0;
                all_valid = 1'b1;
                for (int k = 0; k < HALF_WINDOW; k++) begin
                    later_sum += range_window[k].range;
                    prior_sum += range_window[k + HALF_WINDOW + 1].range;
                    all_valid &= range_window[k].valid
                               & range_window[k + HALF_WINDOW + 1].valid;
                end
                if (!all_valid || prior_sum == 0 || later_sum == 0) begin
                    res.kind = KIND_EDGE;
                end else begin
                    diff  = (prior_sum > later_sum) ? prior_sum - later_sum
                                                    : later_sum - prior_sum;
                    limit = HALF_WINDOW * tolerance;
                    if (diff < limit) begin
                        res.kind = KIND_FLAT;
                    end else begin
                        res.kind = KIND_CORNER;
                        if (corners != COUNT_MAX) corners++;
                    end
                end
                res.position     = POS_W'(j - HALF_WINDOW);
                res.corner_count = corners;
                res.last_of_scan = 1'b0;
                queued_classes.push_back(res);
            end
        end
    endtask

    // Monitor all three ports on the rising edge
    always @(posedge aclk) begin
        out_t exp_res;
        if (!aresetn) begin
            max_range = MAX_RANGE_RESET;
            tolerance = TOLERANCE_RESET;
            clear_scan_state();
            queued_classes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_MAX_RANGE) max_range = pwdata[RANGE_W-1:0];
                else                           tolerance = pwdata[TOL_W-1:0];
            end
            // results first: an output transfer always belongs to an older sample
            if (m_valid && m_ready) begin
                if (queued_classes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pos=%0d kind=%s",
                                              m_data.position, m_data.kind.name()));
                end else begin
                    exp_res = queued_classes.pop_front();
                    if (m_data !== exp_res)
                        report_mismatch($sformatf(
                            "got pos=%0d kind=%0d count=%0d last=%0b, want %0d/%0d/%0d/%0b",
                            m_data.position, m_data.kind, m_data.corner_count,
                            m_data.last_of_scan, exp_res.position, exp_res.kind,
                            exp_res.corner_count, exp_res.last_of_scan));
                end
            end
            if (s_valid && s_ready) classify_sample(s_data);
        end
        outstanding <= queued_classes.size();
    end

endmodule

[tb/sv/lidar_corner_edge_detector_tb.sv]
// Testbench top for the lidar corner and wall-edge detector.
// Drives samples, configuration and result back-pressure; checking is done by
// lced_result_checker. Depends on lced_pkg and the detector RTL.
`timescale 1ns / 1ps

module lidar_corner_edge_detector_tb;
    import lced_pkg::*;

    localparam int QUIET_LIMIT = 3000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_t                 s_data;
    logic                m_valid;
    logic                m_ready;
    out_t                m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    int                  error_count;
    int                  outstanding;

    // Stimulus shaping state
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cur_max        = 5010;
    int cur_tol        = 400;
    int phase_sent;
    int quiet_cycles   = 0;

    always #6 aclk = ~aclk;

    lidar_corner_edge_detector DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lced_result_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    // Result back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: ends the run when no transfer happens for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // One sample transfer; valid stays high into the next call if no gap follows
    task automatic send_sample(input int range_val, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data.range_mm <= RANGE_W'(range_val);
        s_data.scan_end <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        phase_sent++;
    endtask

    // Drop valid and wait until every result is in and the pipeline is empty
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic reg_sel, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({reg_sel, 2'b00});
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic int pick_base();
        if ($urandom_range(99) < 10) return 0;
        if (cur_max <= 1) return int'($urandom_range(65535));
        return int'($urandom_range(cur_max - 1, 1));
    endfunction

    // One scan: a wall level that steps now and then, with jitter and dropouts
    task automatic send_scan(input int len);
        int base;
        int jit;
        int v;
        int r;
        base = pick_base();
        jit  = int'($urandom_range(cur_tol));
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(99) < 8) base = pick_base();
            r = $urandom_range(99);
            if (r < 4)           v = 65535;
            else if (r < 7)      v = int'($urandom_range(65535));
            else if (r < 9)      v = cur_max;
            else if (base == 0)  v = 0;
            else                 v = base - jit + int'($urandom_range(2 * jit));
            if (v < 0)     v = 0;
            if (v > 65535) v = 65535;
            send_sample(v, n == len - 1);
        end
    endtask

    task automatic run_phase(input int max_val, input int tol_val, input int idle_pct,
                             input int stall_pct, input int items);
        int r;
        write_reg(REG_MAX_RANGE, max_val);
        write_reg(REG_TOLERANCE, tol_val);
        cur_max        = max_val;
        cur_tol        = tol_val;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        phase_sent     = 0;
        while (phase_sent < items) begin
            r = $urandom_range(99);
            if (r < 20)      send_scan($urandom_range(11, 1));
            else if (r < 90) send_scan($urandom_range(48, 12));
            else             send_scan($urandom_range(200, 49));
        end
        settle();
    endtask

    initial begin
        int v;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        m_ready <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Scan closed before any centre can be classified
        send_sample(0, 1'b0);
        send_sample(65535, 1'b0);
        send_sample(1234, 1'b1);

        // Zero-sum edge, corners, flat wall, invalid and at-limit samples, summary
        for (int n = 0; n < 21; n++) begin
            if (n < 6)        v = 0;
            else if (n < 17)  v = 1000;
            else if (n == 17) v = 4000;
            else if (n == 18) v = 65535;
            else if (n == 19) v = 5010;
            else              v = 0;
            send_sample(v, n == 20);
        end
        settle();

        run_phase(65535, 0,     0,  0,  300);
        run_phase(0,     13107, 82, 0,  250);
        run_phase(3000,  60,    0,  82, 300);
        run_phase(65535, 13107, 9,  9,  300);
        run_phase(40000, 2000,  82, 0,  300);
        run_phase(5010,  400,   0,  82, 300);

        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lced_pkg.sv
hw/rtl/lidar_corner_edge_detector.sv
hw/rtl/lced_checker.sv
tb/sv/lced_result_checker.sv
tb/sv/lidar_corner_edge_detector_tb.sv
